[rtl/core/aabb_pkg.sv]
// ----------------------------------------------------------------------------
// aabb_pkg
// Shared types for the box pair overlap and push-apart block.
// ----------------------------------------------------------------------------
package aabb_pkg;

  // Axis code reported on push_axis_o
  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  localparam int unsigned NumAxes = 3;

endpackage

[rtl/core/aabb_pair_overlap_resolve.sv]
// ----------------------------------------------------------------------------
// aabb_pair_overlap_resolve
// Overlap test and push-apart for one pair of axis-aligned boxes per request.
// ----------------------------------------------------------------------------
//
//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------------
//  in      | in_valid_i / in_ready_o    | a_x..b_z, a_size, b_size, statics
//  out     | out_valid_o / out_ready_i  | hit, push_axis, a_new_*, b_new_*
//
//  Two register stages, input then result; out_valid_o rises when a request
//  moves into the result register. One request/cycle unless the output stalls.
//  The add/compare/select path between the two stages sets the clock.
//  Reset clears only the two stage valid bits; payload registers are free.
//  A stalled result holds in the result register while the input register
//  still takes one more request; in_ready_o drops when both are full.
// ----------------------------------------------------------------------------
module aabb_pair_overlap_resolve #(
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned SIZE_BITS  = 20
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [COORD_BITS-1:0]          a_x_i,
  input  logic signed [COORD_BITS-1:0]          a_y_i,
  input  logic signed [COORD_BITS-1:0]          a_z_i,
  input  logic signed [COORD_BITS-1:0]          b_x_i,
  input  logic signed [COORD_BITS-1:0]          b_y_i,
  input  logic signed [COORD_BITS-1:0]          b_z_i,
  input  logic [aabb_pkg::NumAxes*SIZE_BITS-1:0] a_size_i,
  input  logic [aabb_pkg::NumAxes*SIZE_BITS-1:0] b_size_i,
  input  logic                                  a_static_i,
  input  logic                                  b_static_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  hit_o,
  output logic [1:0]                            push_axis_o,
  output logic signed [COORD_BITS-1:0]          a_new_x_o,
  output logic signed [COORD_BITS-1:0]          a_new_y_o,
  output logic signed [COORD_BITS-1:0]          a_new_z_o,
  output logic signed [COORD_BITS-1:0]          b_new_x_o,
  output logic signed [COORD_BITS-1:0]          b_new_y_o,
  output logic signed [COORD_BITS-1:0]          b_new_z_o
);
  import aabb_pkg::*;

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned SB = SIZE_BITS;
  // extent (min + size), difference, and moved-corner widths
  localparam int unsigned EW = ((CB > SB + 1) ? CB : SB + 1) + 1;
  localparam int unsigned DW = EW + 1;
  localparam int unsigned NW = DW + 1;

  function automatic logic signed [CB-1:0] sat_f(input logic signed [NW-1:0] v);
    logic [NW-CB:0] top;
    top = v[NW-1:CB-1];
    if ((&top) || !(|top)) begin
      return v[CB-1:0];
    end
    return {v[NW-1], {(CB-1){~v[NW-1]}}};
  endfunction

  // ---------------- stage 1: input register ----------------
  logic                   v1_q;
  logic signed [CB-1:0]   a_min_q [NumAxes];
  logic signed [CB-1:0]   b_min_q [NumAxes];
  logic [NumAxes*SB-1:0]  a_size_q, b_size_q;
  logic                   a_st_q, b_st_q;

  // ---------------- stage 2: result register ----------------
  logic                   v2_q;
  logic                   hit_q;
  axis_e                  axis_q;
  logic signed [CB-1:0]   a_new_q [NumAxes];
  logic signed [CB-1:0]   b_new_q [NumAxes];

  logic s2_ready, s1_load, s2_load;

  assign s2_ready   = !v2_q || out_ready_i;
  assign s2_load    = v1_q && s2_ready;
  assign in_ready_o = !v1_q || s2_ready;
  assign s1_load    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        v1_q <= in_valid_i;
      end
      if (s2_ready) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      a_min_q[0] <= a_x_i;
      a_min_q[1] <= a_y_i;
      a_min_q[2] <= a_z_i;
      b_min_q[0] <= b_x_i;
      b_min_q[1] <= b_y_i;
      b_min_q[2] <= b_z_i;
      a_size_q   <= a_size_i;
      b_size_q   <= b_size_i;
      a_st_q     <= a_static_i;
      b_st_q     <= b_static_i;
    end
  end

  // ---------------- overlap and push logic ----------------
  logic signed [EW-1:0]  amax [NumAxes];
  logic signed [EW-1:0]  bmax [NumAxes];
  logic signed [DW-1:0]  d1 [NumAxes];
  logic signed [DW-1:0]  d2 [NumAxes];
  logic signed [DW-1:0]  ov [NumAxes];
  logic [NumAxes-1:0]    axis_hit;
  logic                  hit_d;
  axis_e                 axis_d;
  logic [NumAxes-1:0]    sel_oh;
  logic signed [DW-1:0]  o_sel, da, db;
  logic signed [NW-1:0]  a_nw [NumAxes];
  logic signed [NW-1:0]  b_nw [NumAxes];

  always_comb begin
    for (int i = 0; i < NumAxes; i++) begin
      amax[i] = EW'(a_min_q[i]) + $signed(EW'(a_size_q[i*SB +: SB]));
      bmax[i] = EW'(b_min_q[i]) + $signed(EW'(b_size_q[i*SB +: SB]));
      d1[i]   = DW'(amax[i]) - DW'(b_min_q[i]);
      d2[i]   = DW'(bmax[i]) - DW'(a_min_q[i]);
      ov[i]   = (d1[i] < d2[i]) ? d1[i] : d2[i];
      axis_hit[i] = !d1[i][DW-1] && !d2[i][DW-1];
    end
    hit_d = &axis_hit;

    // smallest penetration, ties toward x then y
    priority if (!hit_d) begin
      axis_d = AXIS_X;
      sel_oh = '0;
    end else if (ov[0] <= ov[1] && ov[0] <= ov[2]) begin
      axis_d = AXIS_X;
      sel_oh = 3'b001;
    end else if (ov[1] <= ov[2]) begin
      axis_d = AXIS_Y;
      sel_oh = 3'b010;
    end else begin
      axis_d = AXIS_Z;
      sel_oh = 3'b100;
    end

    o_sel = '0;
    for (int i = 0; i < NumAxes; i++) begin
      if (sel_oh[i]) begin
        o_sel = ov[i];
      end
    end

    // o_sel is non-negative on a hit, so the shift is a floor halving
    priority if (a_st_q && b_st_q) begin
      da = '0;
      db = '0;
    end else if (a_st_q) begin
      da = '0;
      db = o_sel;
    end else if (b_st_q) begin
      da = o_sel;
      db = '0;
    end else begin
      da = o_sel >>> 1;
      db = o_sel - (o_sel >>> 1);
    end

    for (int i = 0; i < NumAxes; i++) begin
      a_nw[i] = NW'(a_min_q[i]);
      b_nw[i] = NW'(b_min_q[i]);
      if (sel_oh[i]) begin
        if (a_min_q[i] < b_min_q[i]) begin
          a_nw[i] = NW'(a_min_q[i]) - NW'(da);
          b_nw[i] = NW'(b_min_q[i]) + NW'(db);
        end else begin
          a_nw[i] = NW'(a_min_q[i]) + NW'(da);
          b_nw[i] = NW'(b_min_q[i]) - NW'(db);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      hit_q  <= hit_d;
      axis_q <= axis_d;
      for (int i = 0; i < NumAxes; i++) begin
        a_new_q[i] <= sat_f(a_nw[i]);
        b_new_q[i] <= sat_f(b_nw[i]);
      end
    end
  end

  assign out_valid_o = v2_q;
  assign hit_o       = hit_q;
  assign push_axis_o = axis_q;
  assign a_new_x_o   = a_new_q[0];
  assign a_new_y_o   = a_new_q[1];
  assign a_new_z_o   = a_new_q[2];
  assign b_new_x_o   = b_new_q[0];
  assign b_new_y_o   = b_new_q[1];
  assign b_new_z_o   = b_new_q[2];

  // ---------------- assertions ----------------
  a_nohit_axis_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> push_axis_o == AXIS_X)
    else $error("push axis not x on a miss");

  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v1_q)
    else $error("accepted request lost before stage 1");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !s2_ready |=> v1_q && $stable(a_min_q[0]) && $stable(b_min_q[0]))
    else $error("stage 1 changed under stall");

  a_static_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_load && a_st_q && b_st_q |=>
      a_new_x_o == $past(a_min_q[0]) && b_new_x_o == $past(b_min_q[0]) &&
      a_new_y_o == $past(a_min_q[1]) && b_new_z_o == $past(b_min_q[2]))
    else $error("static pair moved");

endmodule

[tb/aabb_pair_overlap_resolve_tb.sv]
// ----------------------------------------------------------------------------
// aabb_pair_overlap_resolve_tb
// Self-checking bench for the box pair overlap and push-apart block. Box
// pairs go in through a valid/ready request channel. A behavioral predictor
// computes hit, push axis and the resolved corners of every accepted pair,
// and each result is checked against them in order. Directed pairs cover
// the corners and special cases. Random traffic then runs under several
// idle and stall mixes.
// ----------------------------------------------------------------------------
module aabb_pair_overlap_resolve_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aabb_pkg::*;

  localparam int unsigned CW = 24;
  localparam int unsigned SW = 20;
  localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;
  localparam int unsigned CMASK = (1 << CW) - 1;
  localparam int unsigned SMAX = (1 << SW) - 1;
  localparam int ONE = 4096;  // 1.0 in Q.12
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [2:0][CW-1:0]         a_pos;
    logic [2:0][CW-1:0]         b_pos;
    logic [NumAxes*SW-1:0]      a_size;
    logic [NumAxes*SW-1:0]      b_size;
    logic                       a_static;
    logic                       b_static;
  } box_pair_t;

  typedef struct packed {
    logic               hit;
    axis_e              axis;
    logic [2:0][CW-1:0] a_new;
    logic [2:0][CW-1:0] b_new;
  } resolve_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic signed [CW-1:0]   a_x = '0, a_y = '0, a_z = '0;
  logic signed [CW-1:0]   b_x = '0, b_y = '0, b_z = '0;
  logic [NumAxes*SW-1:0]  a_size = '0, b_size = '0;
  logic                   a_static = 1'b0, b_static = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   hit;
  logic [1:0]             push_axis;
  logic signed [CW-1:0]   a_new_x, a_new_y, a_new_z;
  logic signed [CW-1:0]   b_new_x, b_new_y, b_new_z;

  resolve_t      resolved_q[$];
  int unsigned   mismatches = 0;
  int unsigned   idle_pct = 0;
  int unsigned   stall_pct = 0;
  int unsigned   cycle_cnt = 0;

  aabb_pair_overlap_resolve #(
    .COORD_BITS(CW),
    .SIZE_BITS (SW)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .a_x_i      (a_x),
    .a_y_i      (a_y),
    .a_z_i      (a_z),
    .b_x_i      (b_x),
    .b_y_i      (b_y),
    .b_z_i      (b_z),
    .a_size_i   (a_size),
    .b_size_i   (b_size),
    .a_static_i (a_static),
    .b_static_i (b_static),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .hit_o      (hit),
    .push_axis_o(push_axis),
    .a_new_x_o  (a_new_x),
    .a_new_y_o  (a_new_y),
    .a_new_z_o  (a_new_z),
    .b_new_x_o  (b_new_x),
    .b_new_y_o  (b_new_y),
    .b_new_z_o  (b_new_z)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic logic [CW-1:0] clamp_coord(input longint v);
    longint c;
    c = v;
    if (c > CMAX) c = CMAX;
    if (c < CMIN) c = CMIN;
    return c[CW-1:0];
  endfunction

  function automatic resolve_t resolve_pair(input box_pair_t p);
    longint   amin[3], bmin[3], amax[3], bmax[3], pen[3];
    longint   anew[3], bnew[3];
    longint   d1, d2, depth, move_a, move_b;
    logic     overlap;
    int       ax;
    resolve_t r;
    overlap = 1'b1;
    for (int k = 0; k < 3; k++) begin
      amin[k] = $signed(p.a_pos[k]);
      bmin[k] = $signed(p.b_pos[k]);
      amax[k] = amin[k] + longint'(p.a_size[k*SW +: SW]);
      bmax[k] = bmin[k] + longint'(p.b_size[k*SW +: SW]);
      if (!(amax[k] >= bmin[k] && bmax[k] >= amin[k])) overlap = 1'b0;
      d1 = amax[k] - bmin[k];
      d2 = bmax[k] - amin[k];
      pen[k] = (d1 < d2) ? d1 : d2;
      anew[k] = amin[k];
      bnew[k] = bmin[k];
    end
    r.axis = AXIS_X;
    if (overlap) begin
      // ties go to x, then y
      if (pen[0] <= pen[1] && pen[0] <= pen[2]) r.axis = AXIS_X;
      else if (pen[1] <= pen[2]) r.axis = AXIS_Y;
      else r.axis = AXIS_Z;
      ax = r.axis;
      depth = pen[ax];
      if (p.a_static && p.b_static) begin
        move_a = 0;
        move_b = 0;
      end else if (p.a_static) begin
        move_a = 0;
        move_b = depth;
      end else if (p.b_static) begin
        move_a = depth;
        move_b = 0;
      end else begin
        move_a = depth / 2;
        move_b = depth - move_a;
      end
      if (amin[ax] < bmin[ax]) begin
        anew[ax] = amin[ax] - move_a;
        bnew[ax] = bmin[ax] + move_b;
      end else begin
        anew[ax] = amin[ax] + move_a;
        bnew[ax] = bmin[ax] - move_b;
      end
    end
    r.hit = overlap;
    for (int k = 0; k < 3; k++) begin
      r.a_new[k] = clamp_coord(anew[k]);
      r.b_new[k] = clamp_coord(bnew[k]);
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  function automatic void compare_field(input string fname, input logic signed [CW-1:0] want,
                                        input logic signed [CW-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0d, actual %0d", fname, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_results
    resolve_t want;
    if (rst_n && out_valid && out_ready) begin
      if (resolved_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with no pending request: hit %0b axis %0d", hit, push_axis);
      end else begin
        want = resolved_q.pop_front();
        compare_field("hit", CW'(want.hit), CW'(hit));
        compare_field("push_axis", CW'(want.axis), CW'(push_axis));
        compare_field("a_new_x", want.a_new[0], a_new_x);
        compare_field("a_new_y", want.a_new[1], a_new_y);
        compare_field("a_new_z", want.a_new[2], a_new_z);
        compare_field("b_new_x", want.b_new[0], b_new_x);
        compare_field("b_new_y", want.b_new[1], b_new_y);
        compare_field("b_new_z", want.b_new[2], b_new_z);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  task automatic send_pair(input box_pair_t p);
    logic took;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    a_x      <= p.a_pos[0];
    a_y      <= p.a_pos[1];
    a_z      <= p.a_pos[2];
    b_x      <= p.b_pos[0];
    b_y      <= p.b_pos[1];
    b_z      <= p.b_pos[2];
    a_size   <= p.a_size;
    b_size   <= p.b_size;
    a_static <= p.a_static;
    b_static <= p.b_static;
    // ready is stable mid-cycle; sample it there to know if the next edge takes it
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    resolved_q.insert(resolved_q.size(), resolve_pair(p));
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (resolved_q.size() != 0) @(posedge clk);
  endtask

  function automatic box_pair_t build_pair(input int a0, a1, a2, b0, b1, b2,
                                           input int sa0, sa1, sa2, sb0, sb1, sb2,
                                           input bit a_fix, b_fix);
    box_pair_t p;
    p.a_pos[0] = a0[CW-1:0];
    p.a_pos[1] = a1[CW-1:0];
    p.a_pos[2] = a2[CW-1:0];
    p.b_pos[0] = b0[CW-1:0];
    p.b_pos[1] = b1[CW-1:0];
    p.b_pos[2] = b2[CW-1:0];
    p.a_size   = {sa2[SW-1:0], sa1[SW-1:0], sa0[SW-1:0]};
    p.b_size   = {sb2[SW-1:0], sb1[SW-1:0], sb0[SW-1:0]};
    p.a_static = a_fix;
    p.b_static = b_fix;
    return p;
  endfunction

  function automatic box_pair_t random_pair();
    box_pair_t   p;
    int unsigned mode, tie_size, tie_off;
    longint      base, sa, sb, off, pos_b;
    mode       = $urandom_range(99);
    p.a_pos    = (3*CW)'({$urandom(), $urandom(), $urandom()});
    p.b_pos    = (3*CW)'({$urandom(), $urandom(), $urandom()});
    p.a_size   = (NumAxes*SW)'({$urandom(), $urandom()});
    p.b_size   = (NumAxes*SW)'({$urandom(), $urandom()});
    p.a_static = 1'($urandom_range(1));
    p.b_static = 1'($urandom_range(1));
    if (mode < 12) return p;  // raw noise, mostly misses
    tie_size = $urandom_range(SMAX);
    tie_off  = $urandom_range(2 * tie_size);
    for (int k = 0; k < 3; k++) begin
      if (mode < 22)
        base = $urandom_range(1) ? CMAX - $urandom_range(65536) : CMIN + $urandom_range(65536);
      else
        base = longint'($urandom_range(CMASK)) + CMIN;
      case ($urandom_range(3))
        0: begin
          sa = $urandom_range(SMAX);
          sb = $urandom_range(SMAX);
        end
        1: begin
          // shared geometry across axes gives equal penetration
          sa = tie_size;
          sb = tie_size;
        end
        default: begin
          sa = $urandom_range(16384);
          sb = $urandom_range(16384);
        end
      endcase
      if (sa == tie_size && sb == tie_size) begin
        off = longint'(tie_off) - tie_size;
      end else begin
        case ($urandom_range(15))
          0:       off = sa;
          1:       off = -sb;
          2:       off = sa + 1;
          default: off = longint'($urandom_range(32'(sa + sb))) - sb;
        endcase
      end
      pos_b      = base + off;
      p.a_pos[k] = base[CW-1:0];
      p.b_pos[k] = pos_b[CW-1:0];
      p.a_size[k*SW +: SW] = sa[SW-1:0];
      p.b_size[k*SW +: SW] = sb[SW-1:0];
    end
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_corner_extremes();
    int lo, hi, smx;
    lo  = int'(CMIN);
    hi  = int'(CMAX);
    smx = int'(SMAX);
    // degenerate point boxes at the origin touch
    send_pair(build_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // far apart at opposite ends of the range
    send_pair(build_pair(hi, hi, hi, lo, lo, lo, smx, smx, smx, smx, smx, smx, 0, 0));
    // equal corners at the bottom; B pushed below range
    send_pair(build_pair(lo, lo, lo, lo, lo, lo, smx, smx, smx, smx - 5, smx, smx, 0, 0));
    // near the top; A pushed above range, then with B pinned
    send_pair(build_pair(hi - 100, hi - 100, hi - 100, hi - 200, hi - 200, hi - 200,
                         smx, smx, smx, smx, smx, smx, 0, 0));
    send_pair(build_pair(hi - 100, hi - 100, hi - 100, hi - 200, hi - 200, hi - 200,
                         smx, smx, smx, smx, smx, smx, 0, 1));
    // one LSB gap on x: miss
    send_pair(build_pair(0, 0, 0, ONE + 1, 0, 0, ONE, ONE, ONE, ONE, ONE, ONE, 0, 0));
    // faces touch on x: hit with zero push
    send_pair(build_pair(0, 0, 0, ONE, 0, 0, ONE, ONE, ONE, ONE, ONE, ONE, 0, 0));
  endtask

  task automatic test_static_flags();
    // odd x overlap so the dynamic split is uneven
    for (int f = 0; f < 4; f++)
      send_pair(build_pair(0, 0, 0, 3 * ONE + 1, ONE, -2 * ONE,
                           4 * ONE, 4 * ONE, 4 * ONE, 4 * ONE, 4 * ONE, 4 * ONE,
                           f[1], f[0]));
    // y push with A above B, z push with A below B
    send_pair(build_pair(0, 3 * ONE, 0, 0, 0, 0,
                         4 * ONE, 4 * ONE, 4 * ONE, 4 * ONE, 4 * ONE, 4 * ONE, 0, 0));
    send_pair(build_pair(0, 0, 0, 0, 0, 3 * ONE + 3,
                         4 * ONE, 4 * ONE, 4 * ONE, 4 * ONE, 4 * ONE, 4 * ONE, 0, 1));
  endtask

  task automatic test_axis_ties();
    int s;
    s = 4 * ONE;
    send_pair(build_pair(0, 0, 0, 0, 0, 0, s, s, s, s, s, s, 0, 0));
    send_pair(build_pair(0, 0, 0, ONE, 2 * ONE, 2 * ONE, s, s, s, s, s, s, 0, 0));
    send_pair(build_pair(0, 0, 0, 2 * ONE, ONE, 2 * ONE, s, s, s, s, s, s, 0, 0));
    send_pair(build_pair(0, 0, 0, 2 * ONE, 2 * ONE, ONE, s, s, s, s, s, s, 0, 0));
    send_pair(build_pair(0, 0, 0, ONE, ONE, 2 * ONE, s, s, s, s, s, s, 1, 0));
  endtask

  task automatic test_random_traffic(input int unsigned idle, input int unsigned stall,
                                     input int unsigned count);
    idle_pct  = idle;
    stall_pct = stall;
    for (int unsigned n = 0; n < count; n++) begin
      send_pair(random_pair());
      // hold off once mid-phase until the pipe is empty
      if (n == count / 2) wait_results_drained();
    end
    wait_results_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_extremes();
    test_static_flags();
    test_axis_ties();
    wait_results_drained();
    test_random_traffic(0, 0, 160);
    test_random_traffic(53, 0, 160);
    test_random_traffic(0, 53, 160);
    test_random_traffic(34, 34, 170);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && resolved_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
